// ===== rtl/agep_pkg.sv =====
package agep_pkg;

  localparam int unsigned NumBuckets = 360;
  localparam int unsigned BucketBits = 9;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned AngFrac = 7;
  localparam int unsigned AngBits = 16;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepBits = 4;
  localparam int unsigned AccFrac = 20;
  // Differences are scaled by 2^PreShift before the first rotation.
  localparam int unsigned PreShift = 16;
  // Datapath width: differences need 17 bits, scaled by 2^16, CORDIC gain below 1.7.
  localparam int unsigned XyBits = 36;
  localparam int unsigned ZBits = 30;
  localparam int unsigned EntryBits = AngBits + 2 * CoordBits;
  localparam int unsigned AddrBits = 1;

  localparam logic [AngBits-1:0] Turn = AngBits'(360 << AngFrac);
  localparam logic [AngBits-1:0] HalfTurn = AngBits'(180 << AngFrac);
  localparam logic signed [ZBits-1:0] ZFull = ZBits'(360 << AccFrac);
  localparam logic signed [ZBits-1:0] ZHalf = ZBits'(180 << AccFrac);

  localparam logic [AddrBits-1:0] RegFixX = 1'd0;
  localparam logic [AddrBits-1:0] RegFixY = 1'd1;

  typedef struct packed {
    logic [AngBits-1:0] ang;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } entry_t;

  function automatic logic [ZBits-1:0] atan_lut(input logic [StepBits-1:0] i);
    logic [ZBits-1:0] r;
    unique case (i)
      4'd0: r = 30'd47185920;
      4'd1: r = 30'd27855475;
      4'd2: r = 30'd14718068;
      4'd3: r = 30'd7471121;
      4'd4: r = 30'd3750058;
      4'd5: r = 30'd1876857;
      4'd6: r = 30'd938658;
      4'd7: r = 30'd469357;
      4'd8: r = 30'd234682;
      4'd9: r = 30'd117342;
      4'd10: r = 30'd58671;
      4'd11: r = 30'd29335;
      4'd12: r = 30'd14668;
      4'd13: r = 30'd7334;
      4'd14: r = 30'd3667;
      default: r = 30'd1833;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/angular_gap_extremal_points.sv =====
// Angular gap finder. Each start transfer carries one point; the block finds its
// angle around the centre (fix_x, fix_y) with a 16-step iterative CORDIC and files it
// in one of 360 one-degree buckets, keeping the lowest- and highest-angle point of each.
// After reset the block first clears its occupancy memory, one bucket a cycle, and busy
// stays high until that pass ends, so no point is taken before then. An ordinary point
// holds busy high after its transfer through the CORDIC iterations and the angle handoff,
// then a read state and a write state for the bucket memories; only then can the next
// point be taken. A point with last_point set then scans all 360 buckets, one per cycle,
// clearing each as it goes, before busy falls. The one result appears on a one-cycle
// strobe (valid_o) in the same cycle in which busy falls; the receiver cannot stall it
// and must take it in that cycle.
module angular_gap_extremal_points (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [agep_pkg::AddrBits+1:0]        paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [agep_pkg::CoordBits-1:0] point_x_i,
  input  logic signed [agep_pkg::CoordBits-1:0] point_y_i,
  input  logic                                 last_point_i,
  output logic                                 valid_o,
  output logic                                 found_o,
  output logic signed [agep_pkg::CoordBits-1:0] end_x_o,
  output logic signed [agep_pkg::CoordBits-1:0] end_y_o,
  output logic signed [agep_pkg::CoordBits-1:0] start_x_o,
  output logic signed [agep_pkg::CoordBits-1:0] start_y_o
);

  typedef enum logic [8:0] {
    StClear = 9'b000000001,
    StIdle  = 9'b000000010,
    StAng   = 9'b000000100,
    StRead  = 9'b000001000,
    StWrite = 9'b000010000,
    StScan  = 9'b000100000,
    StWrap  = 9'b001000000,
    StFetch = 9'b010000000,
    StEval  = 9'b100000000
  } state_e;

  localparam int unsigned NB = agep_pkg::NumBuckets;
  localparam int unsigned BB = agep_pkg::BucketBits;

  state_e state_q, state_d;
  logic signed [agep_pkg::CoordBits-1:0] fix_x_q, fix_y_q, px_q, py_q;
  logic last_q;
  logic [agep_pkg::AngBits-1:0] ang_q;
  logic [BB-1:0] bkt_q;
  logic [BB:0] idx_q;
  logic [BB:0] pos;
  logic [BB-1:0] first_q, prev_q, open_q, close_q;
  logic [BB:0] best_q;
  logic have_q;
  logic cfg_we;
  logic cor_start, cor_done;
  logic [agep_pkg::AngBits-1:0] cor_ang;
  logic we_lo, we_hi;
  logic [BB-1:0] rd_lo, rd_hi;
  agep_pkg::entry_t ent, lo_rd, hi_rd;
  logic occ_we, occ_wd, occ_rd;
  logic [BB-1:0] occ_wa, occ_ra;
  logic [BB:0] gap, wrap;
  logic [agep_pkg::AngBits:0] theta;

  assign pready = 1'b1;
  assign busy = (state_q != StIdle);
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[agep_pkg::AddrBits+1:2] == agep_pkg::RegFixX) ?
                  32'($signed(fix_x_q)) :
                  (paddr[agep_pkg::AddrBits+1:2] == agep_pkg::RegFixY) ?
                  32'($signed(fix_y_q)) : '0;

  // Centre point registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_x_q <= '0;
      fix_y_q <= '0;
    end else if (cfg_we) begin
      if (paddr[agep_pkg::AddrBits+1:2] == agep_pkg::RegFixX) begin
        fix_x_q <= pwdata[agep_pkg::CoordBits-1:0];
      end
      if (paddr[agep_pkg::AddrBits+1:2] == agep_pkg::RegFixY) begin
        fix_y_q <= pwdata[agep_pkg::CoordBits-1:0];
      end
    end
  end

  assign cor_start = (state_q == StIdle) && start;

  agep_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .dx_i    ((agep_pkg::CoordBits+1)'($signed(point_x_i)) -
              (agep_pkg::CoordBits+1)'($signed(fix_x_q))),
    .dy_i    ((agep_pkg::CoordBits+1)'($signed(point_y_i)) -
              (agep_pkg::CoordBits+1)'($signed(fix_y_q))),
    .done_o  (cor_done),
    .ang_o   (cor_ang)
  );

  assign ent = '{ang: ang_q, x: px_q, y: py_q};
  assign we_lo = (state_q == StWrite) && (!occ_rd || (ang_q < lo_rd.ang));
  assign we_hi = (state_q == StWrite) && (!occ_rd || (ang_q > hi_rd.ang));
  assign rd_lo = (state_q == StFetch) ? close_q : bkt_q;
  assign rd_hi = (state_q == StFetch) ? open_q : bkt_q;

  agep_ram #(.Width(agep_pkg::EntryBits), .Depth(NB)) u_lo (
    .clk_i(clk_i), .we_i(we_lo), .waddr_i(bkt_q), .wdata_i(ent),
    .raddr_i(rd_lo), .rdata_o(lo_rd));

  agep_ram #(.Width(agep_pkg::EntryBits), .Depth(NB)) u_hi (
    .clk_i(clk_i), .we_i(we_hi), .waddr_i(bkt_q), .wdata_i(ent),
    .raddr_i(rd_hi), .rdata_o(hi_rd));

  // Occupancy memory: cleared after reset, set on each point, read and cleared by the scan.
  assign occ_we = (state_q == StClear) || (state_q == StWrite) ||
                  ((state_q == StScan) && (idx_q < (BB+1)'(NB)));
  assign occ_wd = (state_q == StWrite);
  assign occ_wa = (state_q == StWrite) ? bkt_q : idx_q[BB-1:0];
  assign occ_ra = (state_q == StScan) ? idx_q[BB-1:0] : bkt_q;

  agep_ram #(.Width(1), .Depth(NB)) u_occ (
    .clk_i(clk_i), .we_i(occ_we), .waddr_i(occ_wa), .wdata_i(occ_wd),
    .raddr_i(occ_ra), .rdata_o(occ_rd));

  // The scan sees each bucket through the registered read, so pos trails idx_q by one.
  assign pos = idx_q - (BB+1)'(1);
  assign gap = pos - {1'b0, prev_q};
  assign wrap = (BB+1)'(NB) - {1'b0, prev_q} + {1'b0, first_q};
  assign theta = (lo_rd.ang >= hi_rd.ang) ? {1'b0, lo_rd.ang - hi_rd.ang} :
                 {1'b0, lo_rd.ang + agep_pkg::Turn - hi_rd.ang};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (idx_q == (BB+1)'(NB - 1)) state_d = StIdle;
      StIdle:  if (start) state_d = StAng;
      StAng:   if (cor_done) state_d = StRead;
      StRead:  state_d = StWrite;
      StWrite: state_d = last_q ? StScan : StIdle;
      StScan:  if (idx_q == (BB+1)'(NB)) state_d = StWrap;
      StWrap:  state_d = StFetch;
      StFetch: state_d = StEval;
      StEval:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      valid_o <= 1'b0;
      idx_q <= '0;
      have_q <= 1'b0;
      best_q <= '0;
      first_q <= '0;
      prev_q <= '0;
      open_q <= '0;
      close_q <= '0;
      found_o <= 1'b0;
      end_x_o <= '0;
      end_y_o <= '0;
      start_x_o <= '0;
      start_y_o <= '0;
    end else begin
      state_q <= state_d;
      valid_o <= 1'b0;
      // The clearing pass after reset walks every bucket once.
      if (state_q == StClear) begin
        idx_q <= idx_q + 1'b1;
      end
      if (state_q == StWrite) begin
        idx_q <= '0;
        have_q <= 1'b0;
        best_q <= '0;
      end
      // Scan one bucket a cycle for the widest run of empties.
      if (state_q == StScan) begin
        idx_q <= idx_q + 1'b1;
        if ((idx_q != '0) && occ_rd) begin
          if (have_q && (gap > best_q)) begin
            best_q <= gap;
            open_q <= prev_q;
            close_q <= pos[BB-1:0];
          end
          if (!have_q) begin
            first_q <= pos[BB-1:0];
          end
          have_q <= 1'b1;
          prev_q <= pos[BB-1:0];
        end
      end
      // The run that wraps round wins only when strictly wider.
      if (state_q == StWrap) begin
        if (have_q && (wrap > best_q)) begin
          open_q <= prev_q;
          close_q <= first_q;
        end
      end
      if (state_q == StEval) begin
        valid_o <= 1'b1;
        found_o <= have_q && (theta > {1'b0, agep_pkg::HalfTurn});
        if (have_q && (theta > {1'b0, agep_pkg::HalfTurn})) begin
          end_x_o <= lo_rd.x;
          end_y_o <= lo_rd.y;
          start_x_o <= hi_rd.x;
          start_y_o <= hi_rd.y;
        end else begin
          end_x_o <= '0;
          end_y_o <= '0;
          start_x_o <= '0;
          start_y_o <= '0;
        end
      end
    end
  end

  // Point, angle and bucket capture; a bucket is one degree, so it is angle / 128.
  always_ff @(posedge clk_i) begin
    if (cor_start) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
      last_q <= last_point_i;
    end
    if (cor_done) begin
      ang_q <= cor_ang;
      bkt_q <= BB'(cor_ang >> agep_pkg::AngFrac);
    end
  end

endmodule

// ===== rtl/agep_ram.sv =====
module agep_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/agep_cordic.sv =====
module agep_cordic (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [agep_pkg::CoordBits:0]    dx_i,
  input  logic signed [agep_pkg::CoordBits:0]    dy_i,
  output logic                                   done_o,
  output logic [agep_pkg::AngBits-1:0]           ang_o
);

  logic signed [agep_pkg::XyBits-1:0] x_q, x_d, y_q, y_d;
  logic signed [agep_pkg::ZBits-1:0]  z_q, z_d;
  logic [agep_pkg::StepBits-1:0]      step_q, step_d;
  logic                               run_q, run_d, zero_q, zero_d, done_d;
  logic signed [agep_pkg::XyBits-1:0] xs, ys, x0, y0;
  logic signed [agep_pkg::ZBits-1:0]  atn, zf;
  logic [agep_pkg::ZBits-1:0]         zr;
  logic [agep_pkg::AngBits-1:0]       a;

  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;
  assign atn = $signed(agep_pkg::atan_lut(step_q));
  assign x0 = agep_pkg::XyBits'(dx_i) <<< agep_pkg::PreShift;
  assign y0 = agep_pkg::XyBits'(dy_i) <<< agep_pkg::PreShift;

  // One rotation step per cycle through the shared add/shift unit.
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    step_d = step_q;
    run_d = run_q;
    zero_d = zero_q;
    done_d = 1'b0;
    if (start_i) begin
      zero_d = (dx_i == '0) && (dy_i == '0);
      run_d = 1'b1;
      step_d = '0;
      if (dx_i < 0) begin
        x_d = -x0;
        y_d = -y0;
        z_d = agep_pkg::ZHalf;
      end else begin
        x_d = x0;
        y_d = y0;
        z_d = '0;
      end
    end else if (run_q) begin
      if (y_q >= 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atn;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atn;
      end
      step_d = step_q + 1'b1;
      if (step_q == agep_pkg::StepBits'(agep_pkg::CordicSteps - 1)) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      run_q <= run_d;
      done_o <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    zero_q <= zero_d;
  end

  // Wrap into one turn, then round to the output resolution.
  always_comb begin
    zf = zero_q ? agep_pkg::ZHalf : z_q;
    if (zf < 0) begin
      zf = zf + agep_pkg::ZFull;
    end
    if (zf >= agep_pkg::ZFull) begin
      zf = zf - agep_pkg::ZFull;
    end
    zr = (agep_pkg::ZBits'(zf) +
          agep_pkg::ZBits'(1 << (agep_pkg::AccFrac - agep_pkg::AngFrac - 1)))
         >> (agep_pkg::AccFrac - agep_pkg::AngFrac);
    a = zr[agep_pkg::AngBits-1:0];
    ang_o = (a >= agep_pkg::Turn) ? a - agep_pkg::Turn : a;
  end

endmodule
